// ===== hw/rtl/gtc_pkg.sv =====
// Shared constants, request codes and control structs for the graph tree checker.
package gtc_pkg;

  localparam int NODE_W        = 8;
  localparam int NODE_SPACE    = 256;
  localparam int NCOUNT_W      = 9;
  localparam int EDGE_W        = 2 * NODE_W;
  localparam int DEF_MAX_NODES = 256;

  localparam logic REQ_EDGE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic                go;
    logic [NCOUNT_W-1:0] node_count;
  } gtc_walk_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic pass;
  } gtc_walk_sts_t;

endpackage

// ===== hw/rtl/gtc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/gtc_walk.sv =====
// Walk sequencer: depth-first reachability over the stored edges, then visited sweep.
module gtc_walk
  import gtc_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int CNT_W     = $clog2(MAX_NODES)
) (
  input  logic                clk,
  input  logic                rst,
  input  gtc_walk_req_t       req,
  input  logic [CNT_W-1:0]    edge_total,
  output logic [CNT_W-1:0]    edge_raddr,
  input  logic [EDGE_W-1:0]   edge_rdata,
  output gtc_walk_sts_t       sts
);

  localparam int NA_W = $clog2(NODE_SPACE);

  logic [3:0]          st;
  logic [CNT_W-1:0]    ei;
  logic [CNT_W-1:0]    etot;
  logic [NCOUNT_W-1:0] n;
  logic [NCOUNT_W-1:0] sp;
  logic [NCOUNT_W-1:0] cnt;
  logic [NODE_W-1:0]   u;
  logic [NODE_W-1:0]   v;
  logic                ok;

  // state codes on the 4-bit state vector
  localparam logic [3:0] T_CLR    = 4'd0;
  localparam logic [3:0] T_IDLE   = 4'd1;
  localparam logic [3:0] T_SEED   = 4'd2;
  localparam logic [3:0] T_POP    = 4'd3;
  localparam logic [3:0] T_POPW   = 4'd4;
  localparam logic [3:0] T_EREAD  = 4'd5;
  localparam logic [3:0] T_EMATCH = 4'd6;
  localparam logic [3:0] T_VTEST  = 4'd7;
  localparam logic [3:0] T_CHECK  = 4'd8;

  logic                vis_we;
  logic [NA_W-1:0]     vis_waddr;
  logic [0:0]          vis_wdata;
  logic [NA_W-1:0]     vis_raddr;
  logic [0:0]          vis_rdata;
  logic                stk_we;
  logic [NA_W-1:0]     stk_waddr;
  logic [NODE_W-1:0]   stk_wdata;
  logic [NA_W-1:0]     stk_raddr;
  logic [NODE_W-1:0]   stk_rdata;

  logic [NODE_W-1:0]   ea;
  logic [NODE_W-1:0]   eb;
  logic                hit_a;
  logic                hit_b;
  logic [NODE_W-1:0]   v_sel;
  logic                last_edge;
  logic [NCOUNT_W-1:0] sp_m1;
  logic [NCOUNT_W-1:0] cnt_m1;
  logic                chk_fail;
  logic                range_bad;

  assign ea        = edge_rdata[EDGE_W-1:NODE_W];
  assign eb        = edge_rdata[NODE_W-1:0];
  assign hit_a     = (ea == u);
  assign hit_b     = (eb == u);
  assign v_sel     = hit_a ? eb : ea;
  assign last_edge = (ei == etot - 1'b1);
  assign sp_m1     = sp - 1'b1;
  assign cnt_m1    = cnt - 1'b1;
  assign range_bad = ({1'b0, ea} >= n) || ({1'b0, eb} >= n);
  assign chk_fail  = (cnt != '0) && (cnt_m1 < n) && !vis_rdata[0];

  always_comb begin
    edge_raddr = ei;
    vis_we     = 1'b0;
    vis_waddr  = v;
    vis_wdata  = 1'b0;
    vis_raddr  = v;
    stk_we     = 1'b0;
    stk_waddr  = sp[NA_W-1:0];
    stk_wdata  = v;
    stk_raddr  = sp_m1[NA_W-1:0];
    sts.busy   = (st != T_IDLE);
    sts.done   = 1'b0;
    sts.pass   = ok & ~chk_fail;
    unique case (st)
      T_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = cnt[NA_W-1:0];
      end
      T_IDLE: begin
        edge_raddr = '0;
      end
      T_SEED: begin
        vis_we    = 1'b1;
        vis_waddr = ea;
        vis_wdata = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = ea;
      end
      T_EMATCH: begin
        vis_raddr = v_sel;
      end
      T_VTEST: begin
        if (!vis_rdata[0]) begin
          vis_we    = 1'b1;
          vis_wdata = 1'b1;
          stk_we    = 1'b1;
        end
      end
      T_CHECK: begin
        vis_raddr = cnt[NA_W-1:0];
        vis_we    = (cnt != '0);
        vis_waddr = cnt_m1[NA_W-1:0];
        sts.done  = (cnt == NCOUNT_W'(NODE_SPACE));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= T_CLR;
      cnt <= '0;
      ei  <= '0;
      sp  <= '0;
      ok  <= 1'b0;
    end else begin
      unique case (st)
        T_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt[NA_W-1:0] == NA_W'(NODE_SPACE - 1)) begin
            st <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (req.go) begin
            n    <= req.node_count;
            etot <= edge_total;
            ei   <= '0;
            st   <= T_SEED;
          end
        end
        T_SEED: begin
          sp <= NCOUNT_W'(1);
          ok <= 1'b1;
          st <= T_POP;
        end
        T_POP: begin
          if (sp == '0) begin
            cnt <= '0;
            st  <= T_CHECK;
          end else begin
            sp <= sp_m1;
            st <= T_POPW;
          end
        end
        T_POPW: begin
          u  <= stk_rdata;
          ei <= '0;
          st <= T_EREAD;
        end
        T_EREAD: begin
          st <= T_EMATCH;
        end
        T_EMATCH: begin
          if (range_bad) begin
            ok <= 1'b0;
          end
          if (hit_a || hit_b) begin
            v  <= v_sel;
            st <= T_VTEST;
          end else if (last_edge) begin
            st <= T_POP;
          end else begin
            ei <= ei + 1'b1;
            st <= T_EREAD;
          end
        end
        T_VTEST: begin
          if (!vis_rdata[0]) begin
            sp <= sp + 1'b1;
          end
          if (last_edge) begin
            st <= T_POP;
          end else begin
            ei <= ei + 1'b1;
            st <= T_EREAD;
          end
        end
        T_CHECK: begin
          if (chk_fail) begin
            ok <= 1'b0;
          end
          if (cnt == NCOUNT_W'(NODE_SPACE)) begin
            ei <= '0;
            st <= T_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          st <= T_IDLE;
        end
      endcase
    end
  end

  gtc_ram #(
    .WIDTH (1),
    .DEPTH (NODE_SPACE),
    .AW    (NA_W)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  gtc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_SPACE),
    .AW    (NA_W)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule

// ===== hw/rtl/graph_tree_check.sv =====
// Top level of the undirected graph tree checker: intake, edge store, verdict.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------
//  request   | start / busy                 | req_type, from_node, to_node
//  result    | done (one-cycle strobe)      | is_tree
//  config    | cfg_valid / cfg_ready        | node_count
//
// Edges stream in back to back into the edge RAM while busy is low.
// A finish request that fails the node-count, edge-count, self-loop or overflow tests (or
// has a single node) gives its result in the next cycle. Otherwise the walk runs: for each
// node it reaches it pops a stack entry and scans all stored edges, reading each edge and
// matching it, with a visited test for each edge that touches the popped node; then it
// sweeps the visited map. After reset busy stays high while the visited map is cleared.
// Reset is synchronous; done cannot be stalled by the receiver.
module graph_tree_check
  import gtc_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [NODE_W-1:0]   from_node,
  input  logic [NODE_W-1:0]   to_node,
  output logic                done,
  output logic                is_tree,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NCOUNT_W-1:0] node_count
);

  localparam int CNT_W = $clog2(MAX_NODES);

  logic [NCOUNT_W-1:0] n_nodes;
  logic [CNT_W-1:0]    edge_total;
  logic [CNT_W-1:0]    walk_etot;
  logic                bad;
  logic                walk_go;

  logic                accept;
  logic                store_full;
  logic                n_bad;
  logic                cnt_bad;
  logic                early_fail;
  logic                single;

  logic                edge_we;
  logic [CNT_W-1:0]    edge_raddr;
  logic [EDGE_W-1:0]   edge_rdata;

  gtc_walk_req_t       wreq;
  gtc_walk_sts_t       wsts;

  assign cfg_ready  = 1'b1;
  assign busy       = wsts.busy | walk_go;
  assign accept     = start & ~busy;

  // edge store is one entry less deep than MAX_NODES; an edge arriving when it is full marks the graph bad
  assign store_full = (32'(edge_total) >= MAX_NODES - 1);
  assign edge_we    = accept && (req_type == REQ_EDGE) && !store_full;

  // verdicts that need no walk
  assign n_bad      = (n_nodes == '0) || (32'(n_nodes) > MAX_NODES)
                      || (n_nodes > NCOUNT_W'(NODE_SPACE));
  assign cnt_bad    = (32'(edge_total) != 32'(n_nodes) - 32'd1);
  assign early_fail = n_bad | bad | cnt_bad;
  assign single     = (n_nodes == NCOUNT_W'(1));

  assign wreq.go         = walk_go;
  assign wreq.node_count = n_nodes;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_nodes    <= NCOUNT_W'(1);
      edge_total <= '0;
      bad        <= 1'b0;
      walk_go    <= 1'b0;
      done       <= 1'b0;
    end else begin
      walk_go <= 1'b0;
      done    <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        n_nodes <= node_count;
      end
      if (accept) begin
        if (req_type == REQ_EDGE) begin
          if (from_node == to_node) begin
            bad <= 1'b1;  // self loop
          end
          if (store_full) begin
            bad <= 1'b1;  // overflow
          end else begin
            edge_total <= edge_total + 1'b1;
          end
        end else begin
          // finish: clear the graph now, edge RAM stays readable for the walk
          edge_total <= '0;
          bad        <= 1'b0;
          walk_etot  <= edge_total;
          if (early_fail || single) begin
            done    <= 1'b1;
            is_tree <= ~early_fail;
          end else begin
            walk_go <= 1'b1;
          end
        end
      end
      if (wsts.done) begin
        done    <= 1'b1;
        is_tree <= wsts.pass;
      end
    end
  end

  gtc_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_NODES - 1),
    .AW    (CNT_W)
  ) u_edge_store (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total),
    .wdata ({from_node, to_node}),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  gtc_walk #(
    .MAX_NODES (MAX_NODES),
    .CNT_W     (CNT_W)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .req        (wreq),
    .edge_total (walk_etot),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .sts        (wsts)
  );

endmodule
